// ----- rtl/cfc_pkg.sv -----
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types and constants of the checksum frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cfc_pkg;

    localparam int unsigned MAX_PAYLOAD = 256;

    localparam logic [7:0] START_RESET    = 8'h4E;
    localparam logic [7:0] END_RESET      = 8'h56;
    localparam logic [7:0] OVERHEAD_RESET = 8'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_START    = 2'd0;
    localparam logic [1:0] CFG_END      = 2'd1;
    localparam logic [1:0] CFG_OVERHEAD = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_BAD_LEN   = 3'd2;
    localparam logic [2:0] ST_BAD_SUM   = 3'd3;
    localparam logic [2:0] ST_BAD_END   = 3'd4;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] frame_overhead;
    } t_cfg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] msg_type;
        logic [8:0] payload_len;
        logic [2:0] status;
        logic       frame_last;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/cfc_parser.sv -----
// ----------------------------------------------------------------------------
// cfc_parser
// Frame parser state machine: one received byte per accepted transaction,
// producing at most one result in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_parser
    import cfc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire logic [7:0] i_rx_byte,
    input  wire t_cfg    i_cfg,
    output logic         o_res_valid,
    output t_result      o_res
);

    typedef enum logic [7:0] {
        PH_HUNT   = 8'b0000_0001,
        PH_TYPE   = 8'b0000_0010,
        PH_LEN_LO = 8'b0000_0100,
        PH_LEN_HI = 8'b0000_1000,
        PH_DATA   = 8'b0001_0000,
        PH_CK_LO  = 8'b0010_0000,
        PH_CK_HI  = 8'b0100_0000,
        PH_END    = 8'b1000_0000
    } t_phase;

    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [8:0]  r_left, n_left;
    logic [8:0]  r_count, n_count;
    logic [15:0] r_sum, n_sum;
    logic [15:0] r_ck, n_ck;

    logic [15:0] len_full;
    logic [16:0] len_diff;
    logic        len_bad;
    logic [8:0]  left_dec;

    always_comb begin
        len_full = {i_rx_byte, r_len_lo};
        len_diff = {1'b0, len_full} - {9'd0, i_cfg.frame_overhead};
        len_bad  = len_diff[16] || (len_diff[15:0] > MAX_LEN);
        left_dec = (r_left != 9'd0) ? (r_left - 9'd1) : r_left;
    end

    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_len_lo = r_len_lo;
        n_left   = r_left;
        n_count  = r_count;
        n_sum    = r_sum;
        n_ck     = r_ck;

        o_res_valid       = 1'b0;
        o_res.kind        = KIND_STATUS;
        o_res.data_byte   = 8'd0;
        o_res.msg_type    = r_type;
        o_res.payload_len = r_count;
        o_res.status      = ST_OK;
        o_res.frame_last  = 1'b1;

        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == i_cfg.start_marker) begin
                        n_phase = PH_TYPE;
                    end else begin
                        o_res_valid       = 1'b1;
                        o_res.msg_type    = 8'd0;
                        o_res.payload_len = 9'd0;
                        o_res.status      = ST_BAD_START;
                    end
                end
                PH_TYPE: begin
                    n_type  = i_rx_byte;
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len_lo = i_rx_byte;
                    n_phase  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    if (len_bad) begin
                        n_count           = 9'd0;
                        n_left            = 9'd0;
                        n_phase           = PH_HUNT;
                        o_res_valid       = 1'b1;
                        o_res.payload_len = 9'd0;
                        o_res.status      = ST_BAD_LEN;
                    end else begin
                        n_count = len_diff[8:0];
                        n_left  = len_diff[8:0];
                        n_sum   = {8'd0, r_type} + {7'd0, len_diff[8:0]}
                                + {8'd0, i_cfg.start_marker} + {8'd0, i_cfg.end_marker};
                        n_phase = (len_diff[8:0] == 9'd0) ? PH_CK_LO : PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_sum  = r_sum + {8'd0, i_rx_byte};
                    n_left = left_dec;
                    if (left_dec == 9'd0) begin
                        n_phase = PH_CK_LO;
                    end
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_DATA;
                    o_res.data_byte  = i_rx_byte;
                    o_res.frame_last = 1'b0;
                end
                PH_CK_LO: begin
                    n_ck    = {8'd0, i_rx_byte};
                    n_phase = PH_CK_HI;
                end
                PH_CK_HI: begin
                    n_ck    = {i_rx_byte, r_ck[7:0]};
                    n_phase = PH_END;
                end
                PH_END: begin
                    n_phase     = PH_HUNT;
                    o_res_valid = 1'b1;
                    // checksum is judged before the end byte
                    if (r_ck != r_sum) begin
                        o_res.status = ST_BAD_SUM;
                    end else if (i_rx_byte != i_cfg.end_marker) begin
                        o_res.status = ST_BAD_END;
                    end else begin
                        o_res.status = ST_OK;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_type   <= 8'd0;
            r_len_lo <= 8'd0;
            r_left   <= 9'd0;
            r_count  <= 9'd0;
            r_sum    <= 16'd0;
            r_ck     <= 16'd0;
        end else begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_len_lo <= n_len_lo;
            r_left   <= n_left;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_ck     <= n_ck;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cfc_out_buf.sv -----
// ----------------------------------------------------------------------------
// cfc_out_buf
// Two-entry result buffer: an output register plus a skid register, so the
// parser keeps taking bytes while a result waits on the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_out_buf
    import cfc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_space,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    t_result r_head, n_head;
    t_result r_skid, n_skid;
    logic    r_head_valid, n_head_valid;
    logic    r_skid_valid, n_skid_valid;
    logic    pop;

    assign pop     = r_head_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_head_valid;
    assign o_res   = r_head;

    always_comb begin
        n_head       = r_head;
        n_skid       = r_skid;
        n_head_valid = r_head_valid;
        n_skid_valid = r_skid_valid;
        if (pop) begin
            if (r_skid_valid) begin
                // advance skid into head, refill skid
                n_head       = r_skid;
                n_skid       = i_res;
                n_skid_valid = i_push;
            end else begin
                n_head       = i_res;
                n_head_valid = i_push;
            end
        end else if (i_push) begin
            if (!r_head_valid) begin
                n_head       = i_res;
                n_head_valid = 1'b1;
            end else begin
                n_skid       = i_res;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

// ----- rtl/checksum_frame_checker.sv -----
// ----------------------------------------------------------------------------
// checksum_frame_checker
// Byte-stream frame parser with 16-bit additive checksum check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_rx_byte) takes one link byte
//   per transaction. Output channel (o_out_valid / i_out_ready) returns one
//   result per payload byte (kind 0) and one status result per finished or
//   rejected frame (kind 1, frame_last 1). Header, checksum and end bytes
//   of a good frame produce no result of their own until the end byte.
//   Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index,
//   i_cfg_data) writes start marker (0), end marker (1) and frame overhead
//   (2); o_cfg_ready is always high. Write only while the block is idle.
//   Each result is formed combinationally by the parser from its byte
//   and registered into the output register, or into the skid register
//   if that is held. Throughput: one byte per cycle while o_in_ready is high.
//   When the receiver stalls, a second result is held in a skid register;
//   with both full, o_in_ready drops until the receiver takes one.
//   Reset (synchronous, active low) returns the parser to hunting for the
//   start byte, restores the default markers and overhead and empties the
//   result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module checksum_frame_checker
    import cfc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_rx_byte,

    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_kind,
    output logic [7:0]      o_data_byte,
    output logic [7:0]      o_msg_type,
    output logic [8:0]      o_payload_len,
    output logic [2:0]      o_status,
    output logic            o_frame_last,

    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    space;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = space;
    assign accept      = i_in_valid && space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker   <= START_RESET;
            r_cfg.end_marker     <= END_RESET;
            r_cfg.frame_overhead <= OVERHEAD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START:    r_cfg.start_marker   <= i_cfg_data;
                CFG_END:      r_cfg.end_marker     <= i_cfg_data;
                CFG_OVERHEAD: r_cfg.frame_overhead <= i_cfg_data;
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    cfc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cfc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_kind        = out_res.kind;
    assign o_data_byte   = out_res.data_byte;
    assign o_msg_type    = out_res.msg_type;
    assign o_payload_len = out_res.payload_len;
    assign o_status      = out_res.status;
    assign o_frame_last  = out_res.frame_last;

endmodule

`default_nettype wire
